### hdl/lru_key_value_cache_macros.svh
// ----------------------------------------------------------------------------
// lru_key_value_cache assertion macros
// Shared property shorthands for the cache's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define LKVC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lkvc check failed");

// next-cycle implication, disabled while reset is low
`define LKVC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lkvc check failed");

`endif

### hdl/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg
// Types and constants shared by the LRU key-value cache modules.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  localparam int VALUE_W   = 32;
  localparam int OUT_KEY_W = 14;
  localparam int CAP_W     = 5;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  // register index, taken from paddr[2]
  localparam logic REG_CAPACITY = 1'b0;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // request kinds
  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_PUT = 1'b1;

  // command broadcast to every cell
  typedef struct packed {
    logic hit;     // request matched a stored key
    logic insert;  // put of a new key
    logic evict;   // insert drops the least recent entry
  } lkvc_cmd_t;

  // one result word
  typedef struct packed {
    logic                        hit;
    logic signed [VALUE_W-1:0]   read_value;
    logic                        evicted;
    logic        [OUT_KEY_W-1:0] evicted_key;
  } lkvc_res_t;

endpackage

### hdl/lkvc_cell.sv
// ----------------------------------------------------------------------------
// lkvc_cell
// One slot of the recency-ordered chain: compares its key and shifts in the
// entry of its younger neighbor when the command says so.
// ----------------------------------------------------------------------------
module lkvc_cell #(
  parameter int KEY_BITS = 14
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lkvc_pkg::lkvc_cmd_t               cmd_i,
  input  logic [KEY_BITS-1:0]               req_key_i,
  input  logic                              sh_valid_i,
  input  logic [KEY_BITS-1:0]               sh_key_i,
  input  logic signed [lkvc_pkg::VALUE_W-1:0] sh_value_i,
  input  logic                              hit_dn_i,
  output logic                              hit_up_o,
  output logic                              match_o,
  output logic                              valid_o,
  output logic [KEY_BITS-1:0]               key_o,
  output logic signed [lkvc_pkg::VALUE_W-1:0] value_o
);
  import lkvc_pkg::*;

  logic                      valid_r;
  logic [KEY_BITS-1:0]       key_r;
  logic signed [VALUE_W-1:0] value_r;
  logic                      shift;

  // key compare and match chain toward the front
  assign match_o  = valid_r && (key_r == req_key_i);
  assign hit_up_o = hit_dn_i | match_o;

  // hit: cells up to the match shift; insert: up to the first free cell,
  // or up to the last valid cell when evicting
  always_comb begin
    priority if (cmd_i.hit) begin
      shift = hit_up_o;
    end else if (cmd_i.insert) begin
      shift = cmd_i.evict ? valid_r : sh_valid_i;
    end else begin
      shift = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (shift) begin
      valid_r <= sh_valid_i;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (shift) begin
      key_r   <= sh_key_i;
      value_r <= sh_value_i;
    end
  end

  assign valid_o = valid_r;
  assign key_o   = key_r;
  assign value_o = value_r;

endmodule

### hdl/lkvc_out_buf.sv
// ----------------------------------------------------------------------------
// lkvc_out_buf
// Output register with a skid stage so a new word can be taken while the
// previous result is stalled.
// ----------------------------------------------------------------------------
module lkvc_out_buf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 res_valid_i,
  input  lkvc_pkg::lkvc_res_t  res_i,
  output logic                 full_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output lkvc_pkg::lkvc_res_t  out_res_o
);
  import lkvc_pkg::*;

  logic      out_valid_r;
  logic      skid_valid_r;
  lkvc_res_t out_r;
  lkvc_res_t skid_r;
  logic      held;

  assign held = out_valid_r && out_stall_i;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (held) begin
      if (res_valid_i) begin
        skid_valid_r <= 1'b1;
      end
    end else begin
      out_valid_r  <= skid_valid_r | res_valid_i;
      skid_valid_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (held) begin
      if (res_valid_i) begin
        skid_r <= res_i;
      end
    end else if (skid_valid_r) begin
      out_r <= skid_r;
    end else if (res_valid_i) begin
      out_r <= res_i;
    end
  end

  assign full_o      = skid_valid_r;
  assign out_valid_o = out_valid_r;
  assign out_res_o   = out_r;

endmodule

### hdl/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one request word: mode (0 get,
//   1 put), key and value. Result channel (out_valid/out_stall) returns one
//   word per request: hit, read_value, evicted, evicted_key.
//   Entries sit in a chain of cells ordered by recency, most recent in cell 0.
//   Every cell compares its key in the same cycle; a hit or an insert shifts
//   the cells ahead of the target one place back, and the result word is
//   registered in the output register, or in the skid stage while that is
//   held under out_stall; throughput is one request per cycle while in_stall is low.
//   An output register plus a skid stage hold up to two results; in_stall
//   rises only when both are full under out_stall.
//   The capacity register (APB, address 0) limits entries in use before
//   eviction starts; 0 acts as 1, values above MAX_ENTRIES saturate.
//   Reset empties the chain and sets capacity to 16; no clearing pass.
// ----------------------------------------------------------------------------
`include "lru_key_value_cache_macros.svh"

module lru_key_value_cache #(
  parameter int MAX_ENTRIES = 16,
  parameter int KEY_BITS    = 14
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // request channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_mode,
  input  logic [KEY_BITS-1:0]                 in_key,
  input  logic signed [lkvc_pkg::VALUE_W-1:0] in_value,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_hit,
  output logic signed [lkvc_pkg::VALUE_W-1:0] out_read_value,
  output logic                                out_evicted,
  output logic [lkvc_pkg::OUT_KEY_W-1:0]      out_evicted_key,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lkvc_pkg::ADDR_W-1:0]         paddr,
  input  logic [lkvc_pkg::DATA_W-1:0]         pwdata,
  output logic [lkvc_pkg::DATA_W-1:0]         prdata,
  output logic                                pready
);
  import lkvc_pkg::*;

  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int CAPX_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic [CAP_W-1:0]  cap_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic [CAPX_W-1:0] cap_x;
  logic [CAPX_W-1:0] cap_eff;

  logic      in_fire;
  logic      buf_full;
  lkvc_cmd_t cmd;
  lkvc_res_t res;
  lkvc_res_t out_res;

  logic                      cell_valid [MAX_ENTRIES];
  logic [KEY_BITS-1:0]       cell_key   [MAX_ENTRIES];
  logic signed [VALUE_W-1:0] cell_value [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]    match_vec;
  logic [MAX_ENTRIES-1:0]    valid_vec;
  logic [MAX_ENTRIES-1:0]    exp_valid;
  logic                      hit_chain  [MAX_ENTRIES+1];

  logic                      hit_any;
  logic signed [VALUE_W-1:0] hit_value;
  logic signed [VALUE_W-1:0] front_value;
  logic [KEY_BITS-1:0]       last_key;
  logic [KEY_BITS+OUT_KEY_W-1:0] last_key_wide;

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_CAPACITY)) begin
      cap_r <= pwdata[CAP_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_CAPACITY) ? DATA_W'(cap_r) : '0;

  // effective capacity
  always_comb begin
    cap_x = CAPX_W'(cap_r);
    priority if (cap_x == '0) begin
      cap_eff = CAPX_W'(1);
    end else if (cap_x > CAPX_W'(MAX_ENTRIES)) begin
      cap_eff = CAPX_W'(MAX_ENTRIES);
    end else begin
      cap_eff = cap_x;
    end
  end

  // request decode
  assign in_stall = buf_full;
  assign in_fire  = in_valid && !in_stall;
  assign hit_any  = hit_chain[0];

  always_comb begin
    cmd.hit    = in_fire && hit_any;
    cmd.insert = in_fire && (in_mode == MODE_PUT) && !hit_any;
    cmd.evict  = cmd.insert && (CAPX_W'(count_r) >= cap_eff);
  end

  // matched value and key of the last valid cell
  always_comb begin
    hit_value = '0;
    last_key  = '0;
    for (int j = 0; j < MAX_ENTRIES; j++) begin
      if (match_vec[j]) begin
        hit_value = hit_value | cell_value[j];
      end
      if (cell_valid[j] && ((j == MAX_ENTRIES - 1) || !valid_vec[(j + 1) % MAX_ENTRIES])) begin
        last_key = last_key | cell_key[j];
      end
    end
  end

  assign front_value   = (hit_any && (in_mode == MODE_GET)) ? hit_value : in_value;
  assign last_key_wide = {{OUT_KEY_W{1'b0}}, last_key};

  // cell chain
  assign hit_chain[MAX_ENTRIES] = 1'b0;

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    logic                      sh_valid;
    logic [KEY_BITS-1:0]       sh_key;
    logic signed [VALUE_W-1:0] sh_value;

    if (g == 0) begin : g_front
      assign sh_valid = 1'b1;
      assign sh_key   = in_key;
      assign sh_value = front_value;
    end else begin : g_link
      assign sh_valid = cell_valid[g-1];
      assign sh_key   = cell_key[g-1];
      assign sh_value = cell_value[g-1];
    end

    lkvc_cell #(
      .KEY_BITS(KEY_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd_i     (cmd),
      .req_key_i (in_key),
      .sh_valid_i(sh_valid),
      .sh_key_i  (sh_key),
      .sh_value_i(sh_value),
      .hit_dn_i  (hit_chain[g+1]),
      .hit_up_o  (hit_chain[g]),
      .match_o   (match_vec[g]),
      .valid_o   (cell_valid[g]),
      .key_o     (cell_key[g]),
      .value_o   (cell_value[g])
    );

    assign valid_vec[g] = cell_valid[g];
    assign exp_valid[g] = (CNT_W'(g) < count_r);
  end

  // fill count
  always_comb begin
    count_nxt = count_r;
    if (cmd.insert && !cmd.evict) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // result word
  always_comb begin
    res.hit         = hit_any;
    res.read_value  = (hit_any && (in_mode == MODE_GET)) ? hit_value : '0;
    res.evicted     = cmd.evict;
    res.evicted_key = cmd.evict ? last_key_wide[OUT_KEY_W-1:0] : '0;
  end

  lkvc_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid_i(in_fire),
    .res_i      (res),
    .full_o     (buf_full),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_res_o  (out_res)
  );

  assign out_hit         = out_res.hit;
  assign out_read_value  = out_res.read_value;
  assign out_evicted     = out_res.evicted;
  assign out_evicted_key = out_res.evicted_key;

  // checks
  `LKVC_ASSERT_IMPL(a_match_onehot0, clk, rst_n, 1'b1, $onehot0(match_vec))
  `LKVC_ASSERT_IMPL(a_valid_packed, clk, rst_n, 1'b1, valid_vec == exp_valid)
  `LKVC_ASSERT_NEXT(a_get_keeps_count, clk, rst_n, in_fire && (in_mode == MODE_GET), $stable(count_r))
  `LKVC_ASSERT_IMPL(a_evict_not_hit, clk, rst_n, out_valid, !(out_evicted && out_hit))

endmodule

### verif/lkvc_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_result_checker
// Watches both channels and the APB port of the LRU key-value cache. It keeps
// its own copy of the entry table and of capacity, computes the result word
// for every accepted request, and compares each accepted result word,
// field by field, with the oldest one still pending.
// ----------------------------------------------------------------------------
module lkvc_result_checker #(
  parameter int NUM_SLOTS = 16,
  parameter int KEY_W     = 14
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic                                in_mode,
  input  logic [KEY_W-1:0]                    in_key,
  input  logic signed [lkvc_pkg::VALUE_W-1:0] in_value,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic                                out_hit,
  input  logic signed [lkvc_pkg::VALUE_W-1:0] out_read_value,
  input  logic                                out_evicted,
  input  logic [lkvc_pkg::OUT_KEY_W-1:0]      out_evicted_key,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lkvc_pkg::ADDR_W-1:0]         paddr,
  input  logic [lkvc_pkg::DATA_W-1:0]         pwdata,
  input  logic                                pready,
  output int                                  mismatches,
  output int                                  outstanding
);
  import lkvc_pkg::*;

  // shadow entry table
  logic                      slot_used  [NUM_SLOTS];
  logic [KEY_W-1:0]          slot_key   [NUM_SLOTS];
  logic signed [VALUE_W-1:0] slot_value [NUM_SLOTS];
  int unsigned               slot_age   [NUM_SLOTS];
  int unsigned               used_count;
  logic [CAP_W-1:0]          capacity_reg;

  lkvc_res_t pending_results[$];
  int        error_count;
  int        result_idx;

  assign mismatches = error_count;

  // slot becomes age 0; entries younger than its old age (all others when
  // it is new) grow one older
  function automatic void make_most_recent(input int slot, input int unsigned old_age,
                                           input logic was_present);
    for (int i = 0; i < NUM_SLOTS; i++)
      if (i != slot && slot_used[i] && (!was_present || slot_age[i] < old_age))
        slot_age[i]++;
    slot_age[slot] = 0;
  endfunction

  // one request against the shadow table; returns the result word it causes
  function automatic lkvc_res_t apply_request(input logic mode, input logic [KEY_W-1:0] key,
                                              input logic signed [VALUE_W-1:0] value);
    lkvc_res_t   res;
    int unsigned limit;
    int unsigned best;
    int          match;
    int          slot;
    res   = '0;
    match = -1;
    slot  = -1;
    best  = 0;
    // capacity 0 acts as 1, above the table size it saturates
    if (capacity_reg == '0)
      limit = 1;
    else if (capacity_reg > NUM_SLOTS)
      limit = NUM_SLOTS;
    else
      limit = 32'(capacity_reg);

    for (int i = 0; i < NUM_SLOTS; i++)
      if (match < 0 && slot_used[i] && slot_key[i] == key)
        match = i;

    if (match >= 0) begin
      res.hit = 1'b1;
      if (mode == MODE_GET)
        res.read_value = slot_value[match];
      else
        slot_value[match] = value;
      make_most_recent(match, slot_age[match], 1'b1);
    end else if (mode == MODE_PUT) begin
      // free slot first, lowest index wins
      if (used_count < limit)
        for (int i = 0; i < NUM_SLOTS; i++)
          if (slot < 0 && !slot_used[i])
            slot = i;
      if (slot >= 0) begin
        used_count++;
      end else begin
        // evict the oldest valid entry
        for (int i = 0; i < NUM_SLOTS; i++)
          if (slot_used[i] && (slot < 0 || slot_age[i] > best)) begin
            slot = i;
            best = slot_age[i];
          end
        if (slot < 0) begin
          slot       = 0;
          used_count = 1;
        end else begin
          res.evicted     = 1'b1;
          res.evicted_key = OUT_KEY_W'(slot_key[slot]);
          slot_used[slot] = 1'b0;
        end
      end
      slot_key[slot]   = key;
      slot_value[slot] = value;
      make_most_recent(slot, 0, 1'b0);
      slot_used[slot]  = 1'b1;
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch
    lkvc_res_t got;
    lkvc_res_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_used[i]  = 1'b0;
        slot_key[i]   = '0;
        slot_value[i] = '0;
        slot_age[i]   = 0;
      end
      used_count   = 0;
      capacity_reg = CAP_RESET;
      pending_results.delete();
      outstanding <= 0;
    end else begin
      // result word leaving the block
      if (out_valid && !out_stall) begin
        got.hit         = out_hit;
        got.read_value  = out_read_value;
        got.evicted     = out_evicted;
        got.evicted_key = out_evicted_key;
        if (pending_results.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("%0t: result %0d arrived with nothing pending: hit=%0b rd=%0d ev=%0b evk=%0d",
                     $realtime, result_idx, got.hit, got.read_value, got.evicted,
                     got.evicted_key);
        end else begin
          want = pending_results.pop_front();
          if (got.hit !== want.hit || got.read_value !== want.read_value ||
              got.evicted !== want.evicted || got.evicted_key !== want.evicted_key) begin
            error_count++;
            if (error_count <= 10)
              $display({"%0t: result %0d wrong: expected hit=%0b rd=%0d ev=%0b evk=%0d, ",
                        "got hit=%0b rd=%0d ev=%0b evk=%0d"},
                       $realtime, result_idx, want.hit, want.read_value, want.evicted,
                       want.evicted_key, got.hit, got.read_value, got.evicted,
                       got.evicted_key);
          end
        end
        result_idx++;
      end

      // capacity write on the APB access cycle
      if (psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY)
        capacity_reg = pwdata[CAP_W-1:0];

      // request word entering the block
      if (in_valid && !in_stall)
        pending_results.push_back(apply_request(in_mode, in_key, in_value));

      outstanding <= pending_results.size();
    end
  end

endmodule

### verif/lru_key_value_cache_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_tb
// Drives get and put requests into the LRU key-value cache through several
// capacity settings, with random bursts on the request side and random stall
// patterns on the result side; the checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module lru_key_value_cache_tb;
  import lkvc_pkg::*;

  localparam int NUM_SLOTS = 16;
  localparam int KEY_W     = 14;

  logic                      clk;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      in_mode = MODE_GET;
  logic [KEY_W-1:0]          in_key = '0;
  logic signed [VALUE_W-1:0] in_value = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      out_hit;
  logic signed [VALUE_W-1:0] out_read_value;
  logic                      out_evicted;
  logic [OUT_KEY_W-1:0]      out_evicted_key;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [ADDR_W-1:0]         paddr = '0;
  logic [DATA_W-1:0]         pwdata = '0;
  logic [DATA_W-1:0]         prdata;
  logic                      pready;

  int mismatches;
  int outstanding;

  // sender burst control
  int burst_left = 4;
  bit gaps_on    = 1'b1;

  // receiver stall pattern
  int unsigned stall_style = 0;
  int unsigned stall_timer = 0;

  lru_key_value_cache #(
    .MAX_ENTRIES(NUM_SLOTS),
    .KEY_BITS   (KEY_W)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_key         (in_key),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_read_value (out_read_value),
    .out_evicted    (out_evicted),
    .out_evicted_key(out_evicted_key),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  lkvc_result_checker #(
    .NUM_SLOTS(NUM_SLOTS),
    .KEY_W    (KEY_W)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_key         (in_key),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_read_value (out_read_value),
    .out_evicted    (out_evicted),
    .out_evicted_key(out_evicted_key),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .mismatches     (mismatches),
    .outstanding    (outstanding)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // receiver stall: a new random style each time the random timer runs out
  always @(posedge clk) begin
    if (stall_timer == 0) begin
      stall_style <= $urandom_range(0, 3);
      stall_timer <= $urandom_range(20, 120);
    end else begin
      stall_timer <= stall_timer - 1;
    end
    case (stall_style)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 9) < 7);
      default: out_stall <= (stall_timer[2:0] < 3);
    endcase
  end

  // one request word; holds until accepted, then maybe a gap
  task automatic send_request(input logic mode, input logic [KEY_W-1:0] key,
                              input logic signed [VALUE_W-1:0] value);
    int gap;
    in_valid <= 1'b1;
    in_mode  <= mode;
    in_key   <= key;
    in_value <= value;
    do @(posedge clk); while (in_stall);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      gap = gaps_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // stop sending and wait for every pending result word
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // APB write of capacity, only with the block idle
  task automatic write_capacity(input int unsigned cap);
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_CAPACITY, 2'b00};
    pwdata  <= DATA_W'(cap[CAP_W-1:0]);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // random requests clustered around a working set so hits and evictions mix
  task automatic run_random_phase(input int count, input int unsigned cap);
    int unsigned      base;
    int unsigned      span;
    logic             mode;
    logic [KEY_W-1:0] key;
    logic signed [VALUE_W-1:0] value;
    write_capacity(cap);
    base    = $urandom_range(0, (1 << KEY_W) - 1);
    span    = $urandom_range(2, 24);
    gaps_on = ($urandom_range(0, 3) != 0);
    repeat (count) begin
      mode = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 9) < 8)
        key = KEY_W'(base + $urandom_range(0, span - 1));
      else
        key = KEY_W'($urandom);
      case ($urandom_range(0, 7))
        0: value = 32'sh8000_0000;
        1: value = 32'sh7FFF_FFFF;
        default: value = $urandom;
      endcase
      send_request(mode, key, value);
    end
  endtask

  initial begin
    int unsigned cap_plan[10] = '{16, 1, 4, 31, 2, 0, 8, 17, 12, 16};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extreme keys and values, miss on empty, overwrite
    send_request(MODE_GET, 14'd0, 32'sd0);
    send_request(MODE_PUT, 14'd0, 32'sh7FFF_FFFF);
    send_request(MODE_PUT, 14'h3FFF, 32'sh8000_0000);
    send_request(MODE_GET, 14'h3FFF, 32'sd5);
    send_request(MODE_GET, 14'd0, 32'sd0);
    send_request(MODE_PUT, 14'd0, -32'sd1);
    send_request(MODE_GET, 14'd0, 32'sd0);
    send_request(MODE_GET, 14'd1234, 32'sd0);
    send_request(MODE_PUT, 14'h2AAA, 32'sh5555_5555);
    send_request(MODE_PUT, 14'h1555, 32'shAAAA_AAAA);

    // capacity lowered below the entry count: new keys evict, count stays
    write_capacity(2);
    send_request(MODE_PUT, 14'd100, 32'sd1);
    send_request(MODE_PUT, 14'd200, 32'sd2);
    send_request(MODE_GET, 14'h2AAA, 32'sd0);
    send_request(MODE_PUT, 14'd300, 32'sd3);

    // capacity zero behaves as one
    write_capacity(0);
    send_request(MODE_PUT, 14'd400, 32'sd4);
    send_request(MODE_PUT, 14'd401, 32'sd5);
    send_request(MODE_GET, 14'd401, 32'sd0);

    // capacity above the table size saturates: fill, then evict
    write_capacity(31);
    for (int i = 0; i < 13; i++)
      send_request(MODE_PUT, KEY_W'(14'h3000 + i), $urandom);

    // random phases across capacity settings
    foreach (cap_plan[p])
      run_random_phase(60, cap_plan[p]);

    drain_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
